FILE: design/epm_pkg.sv
// Package for the encoder position PI motor drive.
// Word layouts, register indexes and reset values; no dependencies.
package epm_pkg;

  localparam int COUNTS_PER_REV_DEF     = 8192;
  localparam int GAIN_FRACTION_BITS_DEF = 16;

  localparam int CNT_W   = 13;
  localparam int REV_W   = 16;
  localparam int POS_W   = 32;
  localparam int GAIN_W  = 24;
  localparam int DUTY_W  = 16;
  localparam int PROD_W  = GAIN_W + POS_W;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = PROD_W + 2;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURRENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PREVIOUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP       = 2'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_CURRENT_RST  = 24'sd38575;
  localparam logic signed [GAIN_W-1:0] GAIN_PREVIOUS_RST = -24'sd38194;
  localparam logic [DUTY_W-1:0]        DRIVE_LIMIT_RST   = 16'd1599;
  localparam logic [DUTY_W-1:0]        PWM_TOP_RST       = 16'd1599;

  // accepted-word strobes and count direction into the position tracker
  typedef struct packed {
    logic tick_take;
    logic event_take;
    logic count_down;
  } pos_ctrl_t;

endpackage

FILE: design/epm_pos_track.sv
// Revolution counter, first-tick offset capture and position/error forming.
// Depends on epm_pkg.
module epm_pos_track import epm_pkg::*; #(
  parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pos_ctrl_t               ctrl,
  input  logic        [CNT_W-1:0] encoder_count,
  input  logic signed [POS_W-1:0] command_position,
  output logic signed [POS_W-1:0] position,
  output logic signed [POS_W-1:0] pos_error
);

  localparam int CntTop = (COUNTS_PER_REV - 1 > 8191) ? 8191 : COUNTS_PER_REV - 1;
  localparam int CprW   = $clog2(COUNTS_PER_REV + 1);
  localparam int ProdW  = REV_W + CprW + 2;
  localparam int WideW  = (ProdW > POS_W + 1) ? ProdW : POS_W + 1;
  localparam logic signed [WideW-1:0] PosMax = (2**31) - 1;
  localparam logic signed [WideW-1:0] PosMin = -(2**31);
  localparam logic signed [CprW:0]    Cpr    = $signed({1'b0, CprW'(COUNTS_PER_REV)});

  logic [CNT_W-1:0]       count_offset;
  logic                   offset_taken;
  logic [REV_W-1:0]       revolutions;
  logic                   double_fire_flag;

  logic [CNT_W-1:0]       count_c;
  logic [CNT_W-1:0]       offset_use;
  logic signed [WideW-1:0] pos_wide;
  logic signed [POS_W:0]  err_wide;

  always_comb begin
    count_c    = (encoder_count > CNT_W'(CntTop)) ? CNT_W'(CntTop) : encoder_count;
    offset_use = offset_taken ? count_offset : count_c;
    pos_wide   = $signed(revolutions) * Cpr
               + $signed({1'b0, count_c}) - $signed({1'b0, offset_use});
    if (pos_wide > PosMax) begin
      position = PosMax[POS_W-1:0];
    end else if (pos_wide < PosMin) begin
      position = PosMin[POS_W-1:0];
    end else begin
      position = pos_wide[POS_W-1:0];
    end
    err_wide = $signed({command_position[POS_W-1], command_position})
             - $signed({position[POS_W-1], position});
    if (err_wide[POS_W] != err_wide[POS_W-1]) begin
      pos_error = err_wide[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_error = err_wide[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_offset     <= '0;
      offset_taken     <= 1'b0;
      revolutions      <= '0;
      double_fire_flag <= 1'b0;
    end else begin
      if (ctrl.tick_take && !offset_taken) begin
        count_offset <= count_c;
        offset_taken <= 1'b1;
      end
      if (ctrl.event_take) begin
        if (ctrl.count_down) begin
          revolutions      <= revolutions - 1'b1;
          double_fire_flag <= 1'b0;
        end else if (!double_fire_flag) begin
          revolutions      <= revolutions + 1'b1;
          double_fire_flag <= 1'b1;
        end else begin
          double_fire_flag <= 1'b0;
        end
      end
    end
  end

  a_offset_holds: assert property (@(posedge clk) disable iff (rst)
    offset_taken |=> offset_taken) else $error("offset flag dropped");
  a_down_clears: assert property (@(posedge clk) disable iff (rst)
    (ctrl.event_take && ctrl.count_down) |=> !double_fire_flag)
    else $error("down overflow left double-fire flag set");
  a_tick_keeps_revs: assert property (@(posedge clk) disable iff (rst)
    (ctrl.tick_take && !ctrl.event_take) |=> $stable(revolutions))
    else $error("tick changed revolution count");

endmodule

FILE: design/encoder_position_pi_motor_drive.sv
// Encoder position PI motor drive, top level.
// Depends on epm_pkg and epm_pos_track.
//
// Input stream s_*: s_tuser is the mode (0 control tick, 1 encoder overflow
// event). Overflow events update the revolution count and give no result.
// Each tick gives one result word on m_*: duty, direction and position.
// Config channel cfg_*: always ready; cfg_index selects gain_current,
// gain_previous, drive_limit or pwm_top. Write only while the block is idle.
//
// Throughput: one word per cycle unless m_tready holds the pipeline. A tick
// result passes through four register stages (error stage, product stage,
// accumulator stage, clamp/output register). The accumulator closes its
// loop on the previous control value.
// Reset clears the offset, revolution count, PI history and all valid bits,
// and loads the register reset values. When m_tready stays low each stage
// holds its word; s_tready falls only once every stage is full.
module encoder_position_pi_motor_drive import epm_pkg::*; #(
  parameter int COUNTS_PER_REV     = COUNTS_PER_REV_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [12:0] encoder_count, [44:13] command_position, [45] count_down
  input  logic [S_DATA_W-1:0]   s_tdata,
  // [0] mode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] duty, [16] reverse, [48:17] position
  output logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data
);

  localparam logic signed [SUM_W-1:0] AccMax =
    $signed({{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] AccMin = ~AccMax;

  logic signed [GAIN_W-1:0] gain_current;
  logic signed [GAIN_W-1:0] gain_previous;
  logic [DUTY_W-1:0]        drive_limit;
  logic [DUTY_W-1:0]        pwm_top;

  logic s_take;
  logic tick_take;
  pos_ctrl_t pos_ctrl;
  logic signed [POS_W-1:0] pos_c;
  logic signed [POS_W-1:0] err_c;
  logic signed [POS_W-1:0] last_error;
  logic signed [ACC_W-1:0] last_control;

  logic ready1, ready2, ready3, ready_out;

  logic                     s1_valid;
  logic signed [POS_W-1:0]  s1_pos, s1_err, s1_prev;
  logic                     s2_valid;
  logic signed [POS_W-1:0]  s2_pos;
  logic signed [PROD_W-1:0] s2_pcur, s2_pprev;
  logic                     s3_valid;
  logic signed [POS_W-1:0]  s3_pos;
  logic signed [ACC_W-1:0]  s3_acc;

  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]         mag, lim, mag_c, duty_w;
  logic [DUTY_W-1:0]        duty_next;

  logic [DUTY_W-1:0]        duty;
  logic                     reverse;
  logic signed [POS_W-1:0]  position;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_current  <= GAIN_CURRENT_RST;
      gain_previous <= GAIN_PREVIOUS_RST;
      drive_limit   <= DRIVE_LIMIT_RST;
      pwm_top       <= PWM_TOP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_CURRENT:  gain_current  <= cfg_data;
        REG_GAIN_PREVIOUS: gain_previous <= cfg_data;
        REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[DUTY_W-1:0];
        REG_PWM_TOP:       pwm_top       <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign ready_out = !m_tvalid || m_tready;
  assign ready3    = !s3_valid || ready_out;
  assign ready2    = !s2_valid || ready3;
  assign ready1    = !s1_valid || ready2;
  assign s_tready  = ready1;
  assign s_take    = s_tvalid && s_tready;
  assign tick_take = s_take && !s_tuser;

  assign pos_ctrl.tick_take  = tick_take;
  assign pos_ctrl.event_take = s_take && s_tuser;
  assign pos_ctrl.count_down = s_tdata[45];

  epm_pos_track #(
    .COUNTS_PER_REV (COUNTS_PER_REV)
  ) u_pos_track (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (pos_ctrl),
    .encoder_count    (s_tdata[12:0]),
    .command_position ($signed(s_tdata[44:13])),
    .position         (pos_c),
    .pos_error        (err_c)
  );

  always_comb begin
    sum = s2_pcur + s2_pprev + last_control;
    if (sum > AccMax) begin
      acc_next = AccMax[ACC_W-1:0];
    end else if (sum < AccMin) begin
      acc_next = AccMin[ACC_W-1:0];
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
    mag       = s3_acc[ACC_W-1] ? ACC_W'(-s3_acc) : ACC_W'(s3_acc);
    lim       = ACC_W'(drive_limit) << GAIN_FRACTION_BITS;
    mag_c     = (mag >= lim) ? lim : mag;
    duty_w    = mag_c >> GAIN_FRACTION_BITS;
    duty_next = (duty_w[DUTY_W-1:0] >= pwm_top) ? pwm_top : duty_w[DUTY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      last_error   <= '0;
      last_control <= '0;
    end else begin
      if (ready1) s1_valid <= tick_take;
      if (ready2) s2_valid <= s1_valid;
      if (ready3) s3_valid <= s2_valid;
      if (ready_out) m_tvalid <= s3_valid;
      if (tick_take) last_error <= err_c;
      if (ready3 && s2_valid) last_control <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_pos  <= pos_c;
      s1_err  <= err_c;
      s1_prev <= last_error;
    end
    if (ready2 && s1_valid) begin
      s2_pos   <= s1_pos;
      s2_pcur  <= gain_current * s1_err;
      s2_pprev <= gain_previous * s1_prev;
    end
    if (ready3 && s2_valid) begin
      s3_pos <= s2_pos;
      s3_acc <= acc_next;
    end
    if (ready_out && s3_valid) begin
      duty     <= duty_next;
      reverse  <= s3_acc[ACC_W-1];
      position <= s3_pos;
    end
  end

  assign m_tdata = {{(M_DATA_W-DUTY_W-1-POS_W){1'b0}}, position, reverse, duty};

  a_event_no_word: assert property (@(posedge clk) disable iff (rst)
    (s_take && s_tuser) |=> !s1_valid) else $error("overflow event entered pipeline");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s2_valid && s3_valid && m_tvalid))
    else $error("input stalled with a free stage");
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !(ready3 && s2_valid) |=> $stable(last_control))
    else $error("control history moved without a word");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the encoder position PI motor drive.
// Predicts duty, direction and position per control tick and checks the
// m_* words in order; depends on epm_pkg and the top-level RTL.
module tb_top;
  import epm_pkg::*;

  localparam logic   MODE_TICK    = 1'b0;
  localparam logic   MODE_EVENT   = 1'b1;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     STALL_LIMIT  = 4000;
  localparam int     SETTLE_WAIT  = 8;
  localparam longint POS_HI       = 64'sd2147483647;
  localparam longint POS_LO       = -64'sd2147483648;
  localparam longint ACC_HI       = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_LO       = -ACC_HI - 64'sd1;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7fffff;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh800000;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              reverse;
    logic [POS_W-1:0]  position;
  } drive_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  // register shadows
  logic signed [GAIN_W-1:0] gain_cur  = GAIN_CURRENT_RST;
  logic signed [GAIN_W-1:0] gain_prev = GAIN_PREVIOUS_RST;
  logic [DUTY_W-1:0]        drive_lim = DRIVE_LIMIT_RST;
  logic [DUTY_W-1:0]        pwm_lim   = PWM_TOP_RST;

  // controller state copy
  longint                  cnt_offset   = 0;
  logic                    offset_valid = 1'b0;
  logic signed [REV_W-1:0] revs         = '0;
  logic                    fire_flag    = 1'b0;
  longint                  prev_err     = 0;
  longint                  prev_ctrl    = 0;

  drive_word_t drive_expected[$];
  drive_word_t want_w;
  int          mismatches = 0;
  int          stall_cycles = 0;
  logic        gaps_on = 1'b1;
  logic        hold_on = 1'b0;
  event        hold_go;

  encoder_position_pi_motor_drive DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint sat32(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("error: drive word %s got %0d expected %0d", field, got, want);
    mismatches++;
  endtask

  task automatic predict_drive(input logic mode, input logic [CNT_W-1:0] cnt_raw,
                               input logic signed [POS_W-1:0] cmd, input logic dn);
    longint      cnt, pos, err, acc, mag, lim, duty;
    drive_word_t w;
    if (mode == MODE_EVENT) begin
      if (dn) begin
        revs = revs - 1'b1;
        fire_flag = 1'b0;
      end else if (!fire_flag) begin
        revs = revs + 1'b1;
        fire_flag = 1'b1;
      end else begin
        fire_flag = 1'b0;
      end
    end else begin
      cnt = (cnt_raw > COUNTS_PER_REV_DEF - 1) ? COUNTS_PER_REV_DEF - 1 : cnt_raw;
      if (!offset_valid) begin
        cnt_offset = cnt;
        offset_valid = 1'b1;
      end
      pos = sat32(longint'(revs) * COUNTS_PER_REV_DEF + cnt - cnt_offset);
      err = sat32(longint'(cmd) - pos);
      acc = longint'(gain_cur) * err + longint'(gain_prev) * prev_err + prev_ctrl;
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
      prev_err = err;
      prev_ctrl = acc;
      w.reverse = (acc < 0);
      mag = (acc < 0) ? -acc : acc;
      lim = longint'(drive_lim) << GAIN_FRACTION_BITS_DEF;
      if (mag >= lim) mag = lim;
      duty = mag >>> GAIN_FRACTION_BITS_DEF;
      if (duty >= pwm_lim) duty = pwm_lim;
      w.duty = duty[DUTY_W-1:0];
      w.position = pos[POS_W-1:0];
      drive_expected.push_back(w);
    end
  endtask

  task automatic send_word(input logic mode, input logic [CNT_W-1:0] cnt,
                           input logic [POS_W-1:0] cmd, input logic dn);
    while (gaps_on && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, dn, cmd, cnt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_drive(mode, cnt, cmd, dn);
  endtask

  task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic [POS_W-1:0] cmd);
    send_word(MODE_TICK, cnt, cmd, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_event(input logic dn);
    send_word(MODE_EVENT, CNT_W'($urandom), $urandom, dn);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_CURRENT:  gain_cur  = val;
      REG_GAIN_PREVIOUS: gain_prev = val;
      REG_DRIVE_LIMIT:   drive_lim = val[DUTY_W-1:0];
      REG_PWM_TOP:       pwm_lim   = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [GAIN_W-1:0] gc, input logic [GAIN_W-1:0] gp,
                           input logic [DUTY_W-1:0] dl, input logic [DUTY_W-1:0] pt);
    settle();
    put_reg(REG_GAIN_CURRENT, gc);
    put_reg(REG_GAIN_PREVIOUS, gp);
    put_reg(REG_DRIVE_LIMIT, {8'd0, dl});
    put_reg(REG_PWM_TOP, {8'd0, pt});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    logic [POS_W-1:0] cmd;
    logic             dn;
    longint           near;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      dn = 1'($urandom_range(0, 1));
      send_event(dn);
      if (!dn && $urandom_range(0, 2) == 0) send_event(1'b0);  // doubled up-overflow
    end else begin
      if (r < 80) begin
        near = longint'(revs) * COUNTS_PER_REV_DEF - cnt_offset;
        near = near + $urandom_range(0, 24575) - 12288;
        cmd = near[POS_W-1:0];
      end else begin
        cmd = $urandom;
      end
      send_tick(CNT_W'($urandom_range(0, 8191)), cmd);
    end
  endtask

  // receiver: random ready, long hold on request, in-order check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch("unexpected", longint'(m_tdata), 0);
      end else begin
        want_w = drive_expected.pop_front();
        if (m_tdata[DUTY_W-1:0] !== want_w.duty)
          report_mismatch("duty", m_tdata[DUTY_W-1:0], want_w.duty);
        if (m_tdata[DUTY_W] !== want_w.reverse)
          report_mismatch("reverse", m_tdata[DUTY_W], want_w.reverse);
        if (m_tdata[DUTY_W+POS_W:DUTY_W+1] !== want_w.position)
          report_mismatch("position", $signed(m_tdata[DUTY_W+POS_W:DUTY_W+1]),
                          $signed(want_w.position));
      end
    end
    m_tready <= !hold_on && (!gaps_on || $urandom_range(0, 99) >= 30);
  end

  always begin
    @(hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // first tick latches the offset: position reads zero
  task automatic test_first_tick_offset();
    send_tick(13'd8191, 32'd0);
  endtask

  task automatic test_small_negative_drive();
    load_regs(-24'sd1, 24'sd0, DRIVE_LIMIT_RST, PWM_TOP_RST);
    send_tick(13'd8191, 32'd1);
    send_tick(13'd8191, 32'd0);
  endtask

  task automatic test_count_extremes();
    load_regs(GAIN_CURRENT_RST, GAIN_PREVIOUS_RST, DRIVE_LIMIT_RST, PWM_TOP_RST);
    send_tick(13'd0, 32'h7fffffff);
    send_tick(13'd4096, 32'd0);
    send_tick(13'd0, 32'h80000000);
  endtask

  task automatic test_overflow_events();
    send_event(1'b0);
    send_event(1'b0);
    send_event(1'b0);
    send_event(1'b1);
    send_event(1'b0);
    send_tick(13'd8191, 32'h80000000);
    send_event(1'b1);
    send_event(1'b1);
    send_event(1'b1);
    send_tick(13'd0, 32'd0);
  endtask

  task automatic test_pwm_top_zero();
    load_regs(GAIN_CURRENT_RST, GAIN_PREVIOUS_RST, 16'hffff, 16'd0);
    send_tick(13'd100, 32'd100000);
    send_tick(13'd200, -32'sd100000);
  endtask

  task automatic test_gain_extremes();
    load_regs(GAIN_MAX, GAIN_MIN, 16'hffff, 16'hffff);
    send_tick(13'd8191, 32'h7fffffff);
    send_tick(13'd0, 32'h80000000);
    load_regs(GAIN_MIN, GAIN_MAX, 16'd0, 16'hffff);
    send_tick(13'd4000, 32'd12345);
    send_tick(13'd17, -32'sd999);
    load_regs(24'sd1000, 24'sd0, 16'hffff, 16'd1);
    send_tick(13'd50, 32'd70000);
  endtask

  task automatic test_revolution_steps();
    int i;
    load_regs(GAIN_CURRENT_RST, GAIN_PREVIOUS_RST, DRIVE_LIMIT_RST, PWM_TOP_RST);
    gaps_on <= 1'b0;
    for (i = 0; i < 24; i++) send_event(1'b1);
    send_tick(13'd1234, 32'd0);
    send_event(1'b0);
    send_tick(13'd1234, 32'd0);
    gaps_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    settle();
    -> hold_go;
    for (i = 0; i < 40; i++) random_item();
    settle();
  endtask

  task automatic test_random_phases();
    logic [GAIN_W-1:0] gc, gp;
    logic [DUTY_W-1:0] dl, pt;
    int                ph, i;
    for (ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin
        gc = GAIN_CURRENT_RST;
        gp = GAIN_PREVIOUS_RST;
      end else if ($urandom_range(0, 1)) begin
        gc = GAIN_W'($urandom_range(0, 131071) - 65536);
        gp = GAIN_W'(-gc + $urandom_range(0, 2047) - 1024);
      end else begin
        gc = GAIN_W'($urandom);
        gp = GAIN_W'($urandom);
      end
      dl = ($urandom_range(0, 3) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(0, 4000));
      pt = ($urandom_range(0, 3) == 0) ? DUTY_W'($urandom_range(1, 65535))
                                       : DUTY_W'($urandom_range(1, 4000));
      load_regs(gc, gp, dl, pt);
      // one whole phase runs with no idling on either side
      gaps_on <= (ph != 1);
      for (i = 0; i < 450; i++) random_item();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_first_tick_offset();
    test_small_negative_drive();
    test_count_extremes();
    test_overflow_events();
    test_pwm_top_zero();
    test_gain_extremes();
    test_revolution_steps();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
